[sv/ibs_pkg.sv]
// Shared constants, register codes and controller/datapath interface types.
`default_nettype none
package ibs_pkg;

  localparam int unsigned MapBits   = 16;
  localparam int unsigned WordLog   = 5;
  localparam int unsigned WordBits  = 2 ** WordLog;
  localparam int unsigned RowBits   = MapBits - WordLog;
  localparam int unsigned Rows      = 2 ** RowBits;
  localparam int unsigned IndexW    = 32;
  localparam int unsigned DistinctW = 17;
  localparam int unsigned OutW      = 120;
  localparam int unsigned CfgIdxW   = 2;

  localparam logic [IndexW-1:0]    WideLimit     = 32'd65535;
  localparam logic [DistinctW-1:0] DistinctLimit = '1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FORMAT     = 2'd0,
    CFG_WIN_START  = 2'd1,
    CFG_WIN_LENGTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic take_byte;
    logic take_end;
    logic mark;
    logic sweep;
  } ibs_cmd_t;

  typedef struct packed {
    logic need_lookup;
    logic out_blocked;
    logic sweep_last;
  } ibs_sts_t;

endpackage
`default_nettype wire

[sv/ibs_datapath.sv]
// Datapath: index assembly, window test, statistics, vertex bitmap and result register.
`default_nettype none
module ibs_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ibs_pkg::ibs_cmd_t             cmd_i,
  output ibs_pkg::ibs_sts_t                  sts_o,
  input  wire logic [7:0]                    data_byte_i,
  input  wire logic                          cfg_we_i,
  input  wire logic [ibs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i,
  input  wire logic                          out_ready_i,
  output logic                               out_valid_o,
  output logic [ibs_pkg::OutW-1:0]           out_data_o
);

  logic                                 fmt_q;
  logic [31:0]                          start_q;
  logic [31:0]                          len_q;
  logic [23:0]                          partial_q, partial_d;
  logic [1:0]                           phase_q, phase_d;
  logic [31:0]                          pos_q, pos_d;
  logic [31:0]                          total_q, total_d;
  logic [31:0]                          min_q, min_d;
  logic [31:0]                          max_q, max_d;
  logic [ibs_pkg::DistinctW-1:0]        distinct_q, distinct_d;
  logic                                 ovf_q, ovf_d;
  logic [ibs_pkg::RowBits-1:0]          sweep_q;
  logic [ibs_pkg::IndexW-1:0]           value_q;
  logic                                 out_valid_q;
  logic [ibs_pkg::OutW-1:0]             out_data_q;

  logic [ibs_pkg::WordBits-1:0]         map_mem [ibs_pkg::Rows];
  logic [ibs_pkg::WordBits-1:0]         rd_data_q;
  logic [ibs_pkg::WordBits-1:0]         wr_data;
  logic [ibs_pkg::RowBits-1:0]          wr_addr;
  logic                                 wr_en;
  logic                                 seen_bit;

  logic [31:0] shifted;
  logic [31:0] assembled;
  logic [31:0] value;
  logic        complete;
  logic        in_window;
  logic        in_map;

  assign shifted   = {24'd0, data_byte_i} << {phase_q, 3'b000};
  assign assembled = {8'd0, partial_q} | shifted;
  assign value     = fmt_q ? assembled : {16'd0, assembled[15:0]};
  assign complete  = fmt_q ? (phase_q == 2'd3) : (phase_q != 2'd0);
  assign in_window = (pos_q >= start_q) &&
                     ((len_q == 32'd0) || ((pos_q - start_q) < len_q));
  assign in_map    = (value >> ibs_pkg::MapBits) == 32'd0;

  assign seen_bit = rd_data_q[value_q[ibs_pkg::WordLog-1:0]];

  assign sts_o.need_lookup = complete && in_window && in_map;
  assign sts_o.out_blocked = out_valid_q && !out_ready_i;
  assign sts_o.sweep_last  = (sweep_q == '1);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = value_q[ibs_pkg::MapBits-1:ibs_pkg::WordLog];
    wr_data = rd_data_q;
    if (cmd_i.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_q;
      wr_data = '0;
    end else if (cmd_i.mark && !seen_bit) begin
      wr_en = 1'b1;
      wr_data[value_q[ibs_pkg::WordLog-1:0]] = 1'b1;
    end
  end

  always_comb begin
    partial_d  = partial_q;
    phase_d    = phase_q;
    pos_d      = pos_q;
    total_d    = total_q;
    min_d      = min_q;
    max_d      = max_q;
    distinct_d = distinct_q;
    ovf_d      = ovf_q;
    if (cmd_i.take_end) begin
      partial_d  = '0;
      phase_d    = '0;
      pos_d      = '0;
      total_d    = '0;
      min_d      = '1;
      max_d      = '0;
      distinct_d = '0;
      ovf_d      = 1'b0;
    end else if (cmd_i.take_byte) begin
      if (!complete) begin
        partial_d = assembled[23:0];
        phase_d   = phase_q + 2'd1;
      end else begin
        partial_d = '0;
        phase_d   = '0;
        if (pos_q != '1) begin
          pos_d = pos_q + 32'd1;
        end
        if (in_window) begin
          if (value < min_q) begin
            min_d = value;
          end
          if (value > max_q) begin
            max_d = value;
          end
          if (total_q != '1) begin
            total_d = total_q + 32'd1;
          end
          if (!in_map) begin
            ovf_d = 1'b1;
          end
        end
      end
    end else if (cmd_i.mark && !seen_bit && (distinct_q != ibs_pkg::DistinctLimit)) begin
      distinct_d = distinct_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q       <= 1'b0;
      start_q     <= '0;
      len_q       <= '0;
      partial_q   <= '0;
      phase_q     <= '0;
      pos_q       <= '0;
      total_q     <= '0;
      min_q       <= '1;
      max_q       <= '0;
      distinct_q  <= '0;
      ovf_q       <= 1'b0;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          ibs_pkg::CFG_FORMAT:     fmt_q   <= cfg_data_i[0];
          ibs_pkg::CFG_WIN_START:  start_q <= cfg_data_i;
          ibs_pkg::CFG_WIN_LENGTH: len_q   <= cfg_data_i;
          default: ;
        endcase
      end
      partial_q  <= partial_d;
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      total_q    <= total_d;
      min_q      <= min_d;
      max_q      <= max_d;
      distinct_q <= distinct_d;
      ovf_q      <= ovf_d;
      if (cmd_i.sweep) begin
        sweep_q <= sweep_q + 1'b1;
      end
      if (cmd_i.take_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      value_q <= value;
    end
    if (cmd_i.take_end) begin
      out_data_q <= {5'd0, (max_q > ibs_pkg::WideLimit), ovf_q, distinct_q,
                     total_q, max_q, min_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_data_q <= map_mem[value_q[ibs_pkg::MapBits-1:ibs_pkg::WordLog]];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

[sv/ibs_ctrl.sv]
// Controller: input handshake, bitmap lookup sequencing and bitmap clear sweep.
`default_nettype none
module ibs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_end_i,
  output logic                    in_ready_o,
  input  wire ibs_pkg::ibs_sts_t  sts_i,
  output ibs_pkg::ibs_cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_MARK
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE) && (!in_end_i || !sts_i.out_blocked);
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.take_byte = accept && !in_end_i;
  assign cmd_o.take_end  = accept && in_end_i;
  assign cmd_o.mark      = (state_q == ST_MARK);
  assign cmd_o.sweep     = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && in_end_i) begin
          state_d = ST_CLEAR;
        end else if (accept && sts_i.need_lookup) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: state_d = ST_MARK;
      ST_MARK:   state_d = ST_IDLE;
      default:   state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

[sv/index_buffer_statistics_unit.sv]
// Top level of the index buffer statistics unit.
// A byte item that does not complete an index, or completes one outside the window
// or beyond the bitmap, needs no lookup; one that marks the bitmap holds off input
// for a registered bitmap read, then a read-modify-write. An end item loads the
// result register at once; then a clear sweep of all 2048 bitmap rows, one 32-bit
// row per cycle, holds off input items. After reset the same sweep runs first.
// Configuration writes are taken in every cycle.
`default_nettype none
module index_buffer_statistics_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  wire logic                         s_axis_tuser,  // [0] command
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [31:0] min_index, [63:32] max_index, [95:64] index_total,
  // [112:96] unique_total, [113] range_overflow, [114] needs_wide_format
  output logic [ibs_pkg::OutW-1:0]          m_axis_tdata,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ibs_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  ibs_pkg::ibs_cmd_t cmd;
  ibs_pkg::ibs_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ibs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_end_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ibs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .data_byte_i (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

[sv/ibs_checker.sv]
// Port-level checker for the index buffer statistics unit and its bind statement.
`default_nettype none
module ibs_checker (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  input  wire logic                         s_axis_tready,
  input  wire logic                         s_axis_tuser,
  input  wire logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  input  wire logic [ibs_pkg::OutW-1:0]     m_axis_tdata
);

  logic [31:0] min_idx;
  logic [31:0] max_idx;
  logic [31:0] total;
  logic [16:0] uniq;

  assign min_idx = m_axis_tdata[31:0];
  assign max_idx = m_axis_tdata[63:32];
  assign total   = m_axis_tdata[95:64];
  assign uniq    = m_axis_tdata[112:96];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_sweep_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("Input accepted right after an end item.");

  a_empty_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (total == 32'd0) |->
      (min_idx == '1) && (max_idx == '0) && (uniq == '0) && !m_axis_tdata[113])
    else $error("Empty result with nonzero statistics.");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (total != 32'd0) |-> (min_idx <= max_idx) && ({15'd0, uniq} <= total))
    else $error("Inconsistent minimum, maximum or counts.");

  a_wide_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[114] == (max_idx[31:16] != 16'd0))
    else $error("Wide format flag does not match maximum.");

endmodule

bind index_buffer_statistics_unit ibs_checker u_ibs_checker (.*);
`default_nettype wire
